### hdl/packet_header_field_extractor_core_macros.svh
// Assertion macros used by the run queue of the header field extractor RTL.
// Depends on nothing; the asserting module must provide clk and rst.
`ifndef PACKET_HEADER_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define PACKET_HEADER_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define PFX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pfx_pkg.sv
// Package for the header field extractor: phase and field codes, the run
// record type and small decode helpers. Depends on nothing.
package pfx_pkg;

  localparam int HdrBytes   = 40;
  localparam int NumSlots   = 6;
  localparam int RunDepthDef = 4;

  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_ETH   = 4'd1;
  localparam logic [3:0] PH_VLAN  = 4'd2;
  localparam logic [3:0] PH_MPLS  = 4'd3;
  localparam logic [3:0] PH_PEEK  = 4'd4;
  localparam logic [3:0] PH_CW    = 4'd5;
  localparam logic [3:0] PH_IP4   = 4'd6;
  localparam logic [3:0] PH_IP6   = 4'd7;
  localparam logic [3:0] PH_EXT   = 4'd8;
  localparam logic [3:0] PH_FRAG  = 4'd9;
  localparam logic [3:0] PH_SKIP  = 4'd10;
  localparam logic [3:0] PH_L4    = 4'd11;

  localparam logic [2:0] KIND_PROTO = 3'd0;
  localparam logic [2:0] KIND_PORT  = 3'd1;
  localparam logic [2:0] KIND_VLAN  = 3'd2;
  localparam logic [2:0] KIND_IPV4  = 3'd3;
  localparam logic [2:0] KIND_MPLS  = 3'd4;
  localparam logic [2:0] KIND_IP6HI = 3'd5;
  localparam logic [2:0] KIND_IP6LO = 3'd6;
  localparam logic [2:0] KIND_END   = 3'd7;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_FRAG = 8'd44;

  typedef struct packed {
    logic [2:0]             n;
    logic [5:0][2:0]        kind;
    logic [5:0][63:0]       val;
    logic [31:0]            off;
  } run_t;

  function automatic logic is_ext(input logic [7:0] p);
    return (p == 8'd0) || (p == 8'd43) || (p == 8'd60) || (p == 8'd135);
  endfunction

  function automatic logic [3:0] skip_target(input logic [7:0] p);
    if (is_ext(p)) return PH_EXT;
    if (p == PROTO_FRAG) return PH_FRAG;
    return PH_L4;
  endfunction

  function automatic logic [5:0] need_of(input logic [3:0] ph, input logic [7:0] p);
    case (ph)
      PH_ETH:  return 6'd14;
      PH_VLAN: return 6'd4;
      PH_MPLS: return 6'd4;
      PH_CW:   return 6'd4;
      PH_IP4:  return 6'd20;
      PH_IP6:  return 6'd40;
      PH_EXT:  return 6'd2;
      PH_FRAG: return 6'd8;
      default: return (p == PROTO_TCP) ? 6'd20 : 6'd8;
    endcase
  endfunction

  // Ethertype decode; PH_START means the walk stops.
  function automatic logic [3:0] type_phase(input logic [15:0] t);
    case (t)
      16'h8100, 16'h88A8, 16'h9100, 16'h9200, 16'h9300: return PH_VLAN;
      16'h8847, 16'h8848: return PH_MPLS;
      16'h0800: return PH_IP4;
      16'h86DD: return PH_IP6;
      default:  return PH_START;
    endcase
  endfunction

endpackage

### hdl/pfx_ifs.sv
// Handshake channels of the header field extractor: the byte input channel
// and the field output channel. Depends on nothing.
interface pfx_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] packet_pos;
  logic        end_of_packet;
  modport source (output valid, data_byte, packet_pos, end_of_packet, input ready);
  modport sink   (input valid, data_byte, packet_pos, end_of_packet, output ready);
endinterface

interface pfx_field_if;
  logic        valid;
  logic        ready;
  logic [2:0]  field_kind;
  logic [63:0] field_value;
  logic [31:0] source_offset;
  logic        final_of_run;
  modport source (output valid, field_kind, field_value, source_offset, final_of_run,
                  input ready);
  modport sink   (input valid, field_kind, field_value, source_offset, final_of_run,
                  output ready);
endinterface

### hdl/packet_header_field_extractor_core.sv
// Top level of the packet header field extractor: the header walker feeding
// a queue of field runs. Depends on pfx_pkg, pfx_ifs, pfx_parse, pfx_runq.
//
//   channel    dir  payload                                          per transfer
//   byte_in    in   data_byte, packet_pos, end_of_packet             one packet byte
//   field_out  out  field_kind, field_value, source_offset,          one field
//                   final_of_run
//
// One byte is taken per cycle while the queue has a free entry. The walker updates
// its state and builds the whole run of fields for that byte in the same cycle, and
// the run goes into a queue of RunDepth entries; its first field is offered once the
// run reaches the head of the queue. A byte is accepted whenever the queue has a free
// entry, so input stalls while RunDepth runs wait, including the cycle in which the
// last field of the head run leaves a full queue.
// A byte that yields many fields (up to six) holds the output for one transfer each.
// Reset is synchronous and clears the walk state and the queue pointers.
module packet_header_field_extractor_core #(
  parameter int RunDepth = pfx_pkg::RunDepthDef
) (
  input  logic         clk,
  input  logic         rst,
  pfx_byte_if.sink     byte_in,
  pfx_field_if.source  field_out
);
  import pfx_pkg::*;

  run_t run;
  logic run_we;
  logic space;

  // The walker: header state, byte buffer and field decode.
  pfx_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .byte_in(byte_in),
    .space  (space),
    .run_we (run_we),
    .run    (run)
  );

  // The queue keeps the input side free while results wait to be taken.
  pfx_runq #(
    .RunDepth(RunDepth)
  ) u_runq (
    .clk      (clk),
    .rst      (rst),
    .run_we   (run_we),
    .run      (run),
    .space    (space),
    .field_out(field_out)
  );

endmodule

### hdl/pfx_parse.sv
// Header walker: holds the parse state and the header byte buffer, and turns
// each accepted byte into a run of up to six fields. Depends on pfx_pkg, pfx_ifs.
module pfx_parse (
  input  logic           clk,
  input  logic           rst,
  pfx_byte_if.sink       byte_in,
  input  logic           space,
  output logic           run_we,
  output pfx_pkg::run_t  run
);
  import pfx_pkg::*;

  logic [3:0]       phase, phase_next;
  logic [5:0]       hcnt, hcnt_next;
  logic [11:0]      skip_rem, skip_rem_next;
  logic [39:0][7:0] hb;
  logic [31:0]      lat, lat_next;
  logic [7:0]       nproto, nproto_next;
  logic [19:0]      plabel, plabel_next;
  logic             pbos, pbos_next;
  logic             done, done_next;
  logic             hb_we;
  logic [5:0]       hb_idx;
  logic             acc;

  assign byte_in.ready = space;
  assign acc = byte_in.valid && space;
  assign run_we = acc && (run.n != 3'd0);

  always_comb begin
    logic [39:0][7:0] v;
    logic [7:0]  b;
    logic [2:0]  n;
    logic [3:0]  r;
    logic [3:0]  ihl;
    logic [11:0] s;
    logic        t_ip6, t_l4, t_go;
    b = byte_in.data_byte;
    v = hb;
    n = 3'd0;
    s = 12'd0;
    r = PH_START;
    ihl = 4'd0;
    t_ip6 = 1'b0;
    t_l4 = 1'b0;
    t_go = 1'b0;
    phase_next = phase;
    hcnt_next = hcnt;
    skip_rem_next = skip_rem;
    lat_next = lat;
    nproto_next = nproto;
    plabel_next = plabel;
    pbos_next = pbos;
    done_next = done;
    hb_we = 1'b0;
    hb_idx = hcnt;
    run.kind = '0;
    run.val = '0;

    if (phase == PH_START) begin
      lat_next = byte_in.packet_pos;
      done_next = 1'b0;
      phase_next = PH_ETH;
      hcnt_next = 6'd0;
    end
    if (!done_next) begin
      if (phase_next == PH_SKIP) begin
        skip_rem_next = skip_rem - 12'd1;
        if (skip_rem_next == 12'd0) begin
          phase_next = skip_target(nproto);
          hcnt_next = 6'd0;
        end
      end else if (phase_next == PH_PEEK) begin
        run.kind[n] = KIND_MPLS; run.val[n] = 64'(plabel); n = n + 3'd1;
        if (!pbos) r = PH_MPLS;
        else begin
          case (b[7:4])
            4'd0:    r = PH_CW;
            4'd4:    r = PH_IP4;
            4'd6:    r = PH_IP6;
            default: r = PH_START;
          endcase
        end
        if (r == PH_START) done_next = 1'b1;
        else begin
          phase_next = r;
          hb_we = 1'b1;
          hb_idx = 6'd0;
          hcnt_next = 6'd1;
        end
      end else if (hcnt_next < 6'd40) begin
        hb_we = 1'b1;
        hb_idx = hcnt_next;
        v[hcnt_next] = b;
        hcnt_next = hcnt_next + 6'd1;
        if (hcnt_next >= need_of(phase_next, nproto)) begin
          case (phase_next)
            PH_ETH: begin
              r = type_phase({v[12], v[13]});
              if (r == PH_START) done_next = 1'b1;
              else begin phase_next = r; hcnt_next = 6'd0; end
            end
            PH_VLAN: begin
              run.kind[n] = KIND_VLAN; run.val[n] = 64'({v[0][3:0], v[1]});
              n = n + 3'd1;
              r = type_phase({v[2], v[3]});
              if (r == PH_START) done_next = 1'b1;
              else begin phase_next = r; hcnt_next = 6'd0; end
            end
            PH_MPLS: begin
              plabel_next = {v[0], v[1], v[2][7:4]};
              pbos_next = v[2][0];
              phase_next = PH_PEEK;
            end
            PH_CW: begin
              phase_next = PH_ETH;
              hcnt_next = 6'd0;
            end
            PH_IP4: begin
              run.kind[n] = KIND_IPV4; run.val[n] = 64'({v[12], v[13], v[14], v[15]});
              n = n + 3'd1;
              run.kind[n] = KIND_IPV4; run.val[n] = 64'({v[16], v[17], v[18], v[19]});
              n = n + 3'd1;
              ihl = v[0][3:0];
              if (ihl < 4'd5) done_next = 1'b1;
              else begin
                nproto_next = v[9];
                run.kind[n] = KIND_PROTO; run.val[n] = 64'(v[9]); n = n + 3'd1;
                s = 12'({ihl, 2'b00}) - 12'd20;
                t_l4 = 1'b1;
              end
            end
            PH_IP6: begin
              run.kind[n] = KIND_IP6HI; run.val[n] = {v[8], v[9], v[10], v[11],
                v[12], v[13], v[14], v[15]}; n = n + 3'd1;
              run.kind[n] = KIND_IP6LO; run.val[n] = {v[16], v[17], v[18], v[19],
                v[20], v[21], v[22], v[23]}; n = n + 3'd1;
              run.kind[n] = KIND_IP6HI; run.val[n] = {v[24], v[25], v[26], v[27],
                v[28], v[29], v[30], v[31]}; n = n + 3'd1;
              run.kind[n] = KIND_IP6LO; run.val[n] = {v[32], v[33], v[34], v[35],
                v[36], v[37], v[38], v[39]}; n = n + 3'd1;
              nproto_next = v[6];
              s = 12'd0;
              t_ip6 = 1'b1;
            end
            PH_EXT: begin
              nproto_next = v[0];
              s = 12'({v[1], 3'b000}) + 12'd6;
              t_ip6 = 1'b1;
            end
            PH_FRAG: begin
              if (({v[2], v[3]} & 16'hfff8) != 16'd0) begin
                run.kind[n] = KIND_PROTO; run.val[n] = 64'(nproto); n = n + 3'd1;
                done_next = 1'b1;
              end else begin
                nproto_next = v[0];
                s = 12'({v[1], 3'b000});
                t_ip6 = 1'b1;
              end
            end
            PH_L4: begin
              run.kind[n] = KIND_PORT; run.val[n] = 64'({v[0], v[1]}); n = n + 3'd1;
              run.kind[n] = KIND_PORT; run.val[n] = 64'({v[2], v[3]}); n = n + 3'd1;
              done_next = 1'b1;
            end
            default: done_next = 1'b1;
          endcase
        end
      end else begin
        done_next = 1'b1;
      end
    end

    // Common tail: choose between an extension, the transport header or a stop.
    if (t_ip6) begin
      if (is_ext(nproto_next) || nproto_next == PROTO_FRAG) t_go = 1'b1;
      else begin
        run.kind[n] = KIND_PROTO; run.val[n] = 64'(nproto_next); n = n + 3'd1;
        t_l4 = 1'b1;
      end
    end
    if (t_l4) begin
      if (nproto_next == PROTO_TCP || nproto_next == PROTO_UDP) t_go = 1'b1;
      else done_next = 1'b1;
    end
    if (t_go) begin
      if (s != 12'd0) begin
        phase_next = PH_SKIP;
        skip_rem_next = s;
      end else begin
        phase_next = skip_target(nproto_next);
        hcnt_next = 6'd0;
      end
    end

    if (byte_in.end_of_packet) begin
      run.kind[n] = KIND_END; run.val[n] = 64'd0; n = n + 3'd1;
      phase_next = PH_START;
      hcnt_next = 6'd0;
      skip_rem_next = 12'd0;
      nproto_next = 8'd0;
      plabel_next = 20'd0;
      pbos_next = 1'b0;
      done_next = 1'b0;
    end
    run.n = n;
    run.off = lat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      hcnt <= 6'd0;
      skip_rem <= 12'd0;
      lat <= 32'd0;
      nproto <= 8'd0;
      plabel <= 20'd0;
      pbos <= 1'b0;
      done <= 1'b0;
    end else if (acc) begin
      phase <= phase_next;
      hcnt <= hcnt_next;
      skip_rem <= skip_rem_next;
      lat <= lat_next;
      nproto <= nproto_next;
      plabel <= plabel_next;
      pbos <= pbos_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hb_we) begin
      hb[hb_idx] <= byte_in.data_byte;
    end
  end

endmodule

### hdl/pfx_runq.sv
// Run queue: stores whole runs of fields and hands them out one field per
// transfer, flagging the last of each run. Depends on pfx_pkg, pfx_ifs, macros.
`include "packet_header_field_extractor_core_macros.svh"
module pfx_runq #(
  parameter int RunDepth = pfx_pkg::RunDepthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           run_we,
  input  pfx_pkg::run_t  run,
  output logic           space,
  pfx_field_if.source    field_out
);
  import pfx_pkg::*;

  localparam int PtrW = (RunDepth > 1) ? $clog2(RunDepth) : 1;
  localparam int CntW = $clog2(RunDepth + 1);

  run_t            mem [RunDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;
  logic [2:0]      slot;
  logic            out_acc, last, pop;
  run_t            head;

  assign head = mem[rd_ptr];
  assign space = (cnt != CntW'(RunDepth));
  assign field_out.valid = (cnt != '0);
  assign field_out.field_kind = head.kind[slot];
  assign field_out.field_value = head.val[slot];
  assign field_out.source_offset = head.off;
  assign last = (slot == head.n - 3'd1);
  assign field_out.final_of_run = last;
  assign out_acc = field_out.valid && field_out.ready;
  assign pop = out_acc && last;

  always_ff @(posedge clk) begin
    if (run_we) begin
      mem[wr_ptr] <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
      slot <= 3'd0;
    end else begin
      if (run_we) begin
        wr_ptr <= (wr_ptr == PtrW'(RunDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(RunDepth - 1)) ? '0 : rd_ptr + 1'b1;
        slot <= 3'd0;
      end else if (out_acc) begin
        slot <= slot + 3'd1;
      end
      if (run_we && !pop) cnt <= cnt + 1'b1;
      else if (pop && !run_we) cnt <= cnt - 1'b1;
    end
  end

  `PFX_ASSERT_NOW(a_no_overfill, run_we, cnt != CntW'(RunDepth), "run written into full queue")
  `PFX_ASSERT_NOW(a_head_nonempty, field_out.valid, head.n != 3'd0, "empty run in queue")
  `PFX_ASSERT_NOW(a_slot_in_run, field_out.valid, slot < head.n, "slot beyond run length")
  `PFX_ASSERT_NEXT(a_pop_drains, pop && !run_we, cnt == $past(cnt) - 1'b1, "pop lost")

endmodule

### sim/tb_top.sv
// Self-checking testbench for packet_header_field_extractor_core.
// Depends on pfx_pkg and the channel interfaces in pfx_ifs.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfx_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [31:0] offset;
    logic        last;
  } field_t;

  typedef struct {
    logic [7:0]  data;
    logic [31:0] offset;
    logic        eop;
    logic        has_expect;
    logic [2:0]  exp_kind;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfx_byte_if  byte_ch ();
  pfx_field_if field_ch ();

  packet_header_field_extractor_core dut (
    .clk(clk), .rst(rst), .byte_in(byte_ch.sink), .field_out(field_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walker state for the prediction; hdr_count and label_word are wider than the block's.
  logic [3:0]  walk_phase;
  logic [11:0] hdr_count;
  logic [11:0] skip_left;
  logic [7:0]  hdr_buf [40];
  logic [31:0] pkt_offset;
  logic [7:0]  next_proto;
  logic [31:0] label_word;
  logic        walk_stopped;

  field_t expected_fields[$];
  field_t run_fields[$];
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  logic   hold_sink = 1'b0;
  logic   timed_out = 1'b0;

  function automatic logic [15:0] hdr16(int i);
    return {hdr_buf[i], hdr_buf[i+1]};
  endfunction

  function automatic logic [31:0] hdr32(int i);
    return {hdr16(i), hdr16(i+2)};
  endfunction

  function automatic logic is_ext_hdr(logic [7:0] p);
    return p == 8'd0 || p == 8'd43 || p == 8'd60 || p == 8'd135;
  endfunction

  task automatic add_field(logic [2:0] kind, logic [63:0] value);
    field_t f;
    f.kind = kind;
    f.value = value;
    f.offset = pkt_offset;
    f.last = 1'b0;
    run_fields.insert(run_fields.size(), f);
  endtask

  task automatic start_header(logic [3:0] ph);
    walk_phase = ph;
    hdr_count = '0;
  endtask

  task automatic after_skip(logic [11:0] skip);
    if (skip != 0) begin
      walk_phase = PH_SKIP;
      skip_left = skip;
    end else if (is_ext_hdr(next_proto)) begin
      start_header(PH_EXT);
    end else if (next_proto == PROTO_FRAG) begin
      start_header(PH_FRAG);
    end else begin
      start_header(PH_L4);
    end
  endtask

  task automatic l4_or_stop(logic [11:0] skip);
    if (next_proto == PROTO_TCP || next_proto == PROTO_UDP) after_skip(skip);
    else walk_stopped = 1'b1;
  endtask

  task automatic after_ip6_header(logic [11:0] skip);
    if (is_ext_hdr(next_proto) || next_proto == PROTO_FRAG) begin
      after_skip(skip);
    end else begin
      add_field(KIND_PROTO, next_proto);
      l4_or_stop(skip);
    end
  endtask

  task automatic dispatch_ethertype(logic [15:0] t);
    case (t)
      16'h8100, 16'h88A8, 16'h9100, 16'h9200, 16'h9300: start_header(PH_VLAN);
      16'h8847, 16'h8848: start_header(PH_MPLS);
      16'h0800: start_header(PH_IP4);
      16'h86DD: start_header(PH_IP6);
      default: walk_stopped = 1'b1;
    endcase
  endtask

  // Header complete: emit its fields and pick the next phase.
  task automatic finish_header();
    logic [3:0] ihl;
    case (walk_phase)
      PH_ETH: dispatch_ethertype(hdr16(12));
      PH_VLAN: begin
        add_field(KIND_VLAN, hdr16(0) & 16'h0FFF);
        dispatch_ethertype(hdr16(2));
      end
      PH_MPLS: begin
        label_word = hdr32(0);
        walk_phase = PH_PEEK;
      end
      PH_CW: start_header(PH_ETH);
      PH_IP4: begin
        add_field(KIND_IPV4, hdr32(12));
        add_field(KIND_IPV4, hdr32(16));
        ihl = hdr_buf[0][3:0];
        if (ihl < 4'd5) begin
          walk_stopped = 1'b1;
        end else begin
          next_proto = hdr_buf[9];
          add_field(KIND_PROTO, next_proto);
          l4_or_stop(12'(ihl * 4 - 20));
        end
      end
      PH_IP6: begin
        add_field(KIND_IP6HI, {hdr32(8), hdr32(12)});
        add_field(KIND_IP6LO, {hdr32(16), hdr32(20)});
        add_field(KIND_IP6HI, {hdr32(24), hdr32(28)});
        add_field(KIND_IP6LO, {hdr32(32), hdr32(36)});
        next_proto = hdr_buf[6];
        after_ip6_header('0);
      end
      PH_EXT: begin
        next_proto = hdr_buf[0];
        after_ip6_header(12'((hdr_buf[1] + 1) * 8 - 2));
      end
      PH_FRAG: begin
        if ((hdr16(2) & 16'hFFF8) != 0) begin
          add_field(KIND_PROTO, next_proto);
          walk_stopped = 1'b1;
        end else begin
          next_proto = hdr_buf[0];
          after_ip6_header(12'((hdr_buf[1] + 1) * 8 - 8));
        end
      end
      PH_L4: begin
        add_field(KIND_PORT, hdr16(0));
        add_field(KIND_PORT, hdr16(2));
        walk_stopped = 1'b1;
      end
      default: walk_stopped = 1'b1;
    endcase
  endtask

  function automatic int header_need();
    case (walk_phase)
      PH_ETH: return 14;
      PH_VLAN, PH_MPLS, PH_CW: return 4;
      PH_IP4: return 20;
      PH_IP6: return 40;
      PH_EXT: return 2;
      PH_FRAG: return 8;
      default: return next_proto == PROTO_TCP ? 20 : 8;
    endcase
  endfunction

  task automatic reset_walker();
    walk_phase = PH_START;
    hdr_count = '0;
    skip_left = '0;
    pkt_offset = '0;
    next_proto = '0;
    label_word = '0;
    walk_stopped = 1'b0;
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
  endtask

  // Predict the fields caused by one accepted byte and queue them.
  task automatic predict_byte(logic [7:0] b, logic [31:0] off, logic eop);
    logic [3:0] ph;
    run_fields.delete();
    if (walk_phase == PH_START) begin
      pkt_offset = off;
      walk_stopped = 1'b0;
      start_header(PH_ETH);
    end
    if (!walk_stopped) begin
      if (walk_phase == PH_SKIP) begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) after_skip('0);
      end else if (walk_phase == PH_PEEK) begin
        add_field(KIND_MPLS, label_word >> 12);
        ph = PH_START;
        if (!label_word[8]) ph = PH_MPLS;
        else if (b[7:4] == 4'd0) ph = PH_CW;
        else if (b[7:4] == 4'd4) ph = PH_IP4;
        else if (b[7:4] == 4'd6) ph = PH_IP6;
        else walk_stopped = 1'b1;
        if (ph != PH_START) begin
          start_header(ph);
          hdr_buf[0] = b;
          hdr_count = 12'd1;
        end
      end else if (hdr_count < 40) begin
        hdr_buf[hdr_count] = b;
        hdr_count++;
        if (hdr_count >= header_need()) finish_header();
      end else begin
        walk_stopped = 1'b1;
      end
    end
    if (eop) begin
      add_field(KIND_END, '0);
      walk_phase = PH_START;
      hdr_count = '0;
      skip_left = '0;
      next_proto = '0;
      label_word = '0;
      walk_stopped = 1'b0;
    end
    if (run_fields.size() > 0) run_fields[run_fields.size()-1].last = 1'b1;
    foreach (run_fields[i]) expected_fields.insert(expected_fields.size(), run_fields[i]);
  endtask

  // Packet under construction, then sent byte by byte.
  logic [7:0] pkt_bytes[$];
  int         byte_gap_max = 12;

  task automatic put_byte(logic [7:0] b);
    pkt_bytes.insert(pkt_bytes.size(), b);
  endtask

  task automatic send_byte(logic [7:0] b, logic [31:0] off, logic eop);
    int gap;
    gap = $urandom_range(0, byte_gap_max);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.packet_pos <= off;
    byte_ch.end_of_packet <= eop;
    do @(posedge clk); while (!byte_ch.ready);
    predict_byte(b, off, eop);
  endtask

  // Sends the packet being built; the whole packet carries one random offset.
  task automatic send_packet();
    logic [31:0] off;
    off = $urandom();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], off, i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  task automatic put16(logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic put_random(int n);
    repeat (n) put_byte(8'($urandom()));
  endtask

  task automatic put_eth(logic [15:0] etype);
    put_random(12);
    put16(etype);
  endtask

  task automatic put_l4(logic [7:0] proto);
    put_random(proto == PROTO_TCP ? 20 : 8);
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 5))
      0, 1: return PROTO_TCP;
      2, 3: return PROTO_UDP;
      4: return 8'(1 + $urandom_range(0, 2) * 57);
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic put_ipv4();
    logic [3:0] ihl;
    logic [7:0] proto;
    ihl = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'd5 + 4'($urandom_range(0, 2));
    proto = pick_proto();
    put_byte({4'd4, ihl});
    put_random(8);
    put_byte(proto);
    put_random(10);
    if (ihl >= 5) begin
      put_random(ihl * 4 - 20);
      put_l4(proto);
    end
  endtask

  task automatic put_ipv6();
    logic [7:0] proto;
    logic [7:0] len;
    int hops;
    proto = ($urandom_range(0, 2) == 0) ? 8'd43 : pick_proto();
    if ($urandom_range(0, 3) == 0) proto = PROTO_FRAG;
    put_byte(8'h60 | 8'($urandom_range(0, 15)));
    put_random(5);
    put_byte(proto);
    put_random(33);
    hops = 0;
    while ((is_ext_hdr(proto) || proto == PROTO_FRAG) && hops < 3) begin
      hops++;
      len = 8'($urandom_range(0, 2));
      if (proto == PROTO_FRAG) begin
        proto = (hops == 3) ? PROTO_UDP : pick_proto();
        put_byte(proto);
        put_byte(len);
        put16($urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 7)));
        put_random(4 + len * 8);
      end else begin
        proto = (hops == 3) ? PROTO_TCP : pick_proto();
        if ($urandom_range(0, 2) == 0 && hops < 3) proto = PROTO_FRAG;
        put_byte(proto);
        put_byte(len);
        put_random(6 + len * 8);
      end
    end
    put_l4(proto);
  endtask

  // Builds one packet with random content and random layering, at times malformed or cut short.
  task automatic build_packet();
    int tags;
    int labels;
    logic [3:0] nib;
    put_random(12);
    tags = $urandom_range(0, 2);
    repeat (tags) begin
      case ($urandom_range(0, 4))
        0: put16(16'h8100);
        1: put16(16'h88A8);
        2: put16(16'h9100);
        3: put16(16'h9200);
        default: put16(16'h9300);
      endcase
      put16(16'($urandom()));
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        put16(16'h0800);
        put_ipv4();
      end
      2, 3: begin
        put16(16'h86DD);
        put_ipv6();
      end
      4: begin
        put16($urandom_range(0, 1) ? 16'h8847 : 16'h8848);
        labels = $urandom_range(1, 3);
        for (int i = 0; i < labels; i++) begin
          put16(16'($urandom()));
          put_byte({4'($urandom()), 3'($urandom()), 1'(i == labels - 1)});
          put_byte(8'($urandom()));
        end
        nib = $urandom_range(0, 5) == 0 ? 4'($urandom()) : 4'($urandom_range(0, 2) * 2);
        if (nib == 4'd2) nib = 4'd4;
        if (nib == 4'd0) begin
          put_random(4);
          put_eth(16'h0800);
          put_ipv4();
        end else if (nib == 4'd4) begin
          put_ipv4();
          pkt_bytes[pkt_bytes.size() - 1] = pkt_bytes[pkt_bytes.size() - 1];
        end else if (nib == 4'd6) begin
          put_ipv6();
        end else begin
          put_byte({nib, 4'($urandom())});
        end
      end
      default: put16(16'($urandom()));
    endcase
    // Occasional truncation or trailing payload.
    if ($urandom_range(0, 5) == 0) begin
      pkt_bytes = pkt_bytes[0 : $urandom_range(0, pkt_bytes.size() - 1)];
    end else if ($urandom_range(0, 2) == 0) begin
      put_random($urandom_range(1, 6));
    end
  endtask

  // Directed rows: reset state, extreme offsets and an unknown ethertype. Expected kind
  // is typed in only where it is obvious; every row's predicted fields are checked at the sink.
  stim_row_t directed[$];

  task automatic row(logic [7:0] d, logic [31:0] off, logic eop, logic has,
                     logic [2:0] k);
    stim_row_t r;
    r.data = d;
    r.offset = off;
    r.eop = eop;
    r.has_expect = has;
    r.exp_kind = k;
    directed.insert(directed.size(), r);
  endtask

  initial begin
    // A one-byte packet at the largest offset, then one at zero: end markers only.
    row(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_END);
    row(8'h00, 32'h0000_0000, 1'b1, 1'b1, KIND_END);
    // Ethernet header with an unknown type of zero, ended right after it.
    for (int i = 0; i < 12; i++) row(8'hAA, 32'h1234_5678, 1'b0, 1'b0, KIND_END);
    row(8'h00, 32'h0, 1'b0, 1'b0, KIND_END);
    row(8'h00, 32'h0, 1'b1, 1'b1, KIND_END);
  end

  task automatic run_directed();
    int first;
    foreach (directed[i]) begin
      first = expected_fields.size();
      send_byte(directed[i].data, directed[i].offset, directed[i].eop);
      if (directed[i].has_expect && expected_fields[$].kind != directed[i].exp_kind) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("directed row %0d: expected kind %0d, predicted %0d", i,
                   directed[i].exp_kind, expected_fields[$].kind);
      end
    end
  endtask

  // Drops valid, then waits until every predicted field has been taken.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed rows, special packets, then random packets.
  int sent_bytes = 0;
  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.packet_pos = '0;
    byte_ch.end_of_packet = 1'b0;
    reset_walker();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    // IPv4 with a short header length: both addresses, then the walk stops.
    put_eth(16'h0800);
    put_byte(8'h44);
    put_random(19);
    send_packet();
    // IPv6 non-first fragment.
    put_eth(16'h86DD);
    put_byte(8'h60);
    put_random(5);
    put_byte(PROTO_FRAG);
    put_random(33);
    put_byte(PROTO_TCP);
    put_byte(8'h00);
    put16(16'hFFF8);
    put_random(4);
    send_packet();
    // Sender pauses until every expected field has come back.
    wait_drained();
    // Bursts with no gaps while the sink is held off for a long stretch.
    byte_gap_max = 0;
    hold_sink <= 1'b1;
    repeat (3) begin
      build_packet();
      send_packet();
    end
    byte_gap_max = 12;
    while (sent_bytes < 120) begin
      build_packet();
      sent_bytes += pkt_bytes.size();
      if ($urandom_range(0, 9) == 0) byte_gap_max = 0;
      else if ($urandom_range(0, 4) == 0) byte_gap_max = 12;
      send_packet();
      if (sent_bytes > 40 && sent_bytes < 100) wait_drained();
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && !timed_out) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Long hold-off of the sink, counted in its own process.
  initial begin
    wait (hold_sink);
    repeat (200) @(posedge clk);
    hold_sink <= 1'b0;
  end

  // Sink: draws a wait per field, then checks each transfer.
  initial begin
    int gap;
    field_t got;
    field_t want;
    field_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_sink) begin
        field_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_sink) @(posedge clk);
      end
      field_ch.ready <= 1'b1;
      do @(posedge clk); while (!field_ch.valid);
      got = '{field_ch.field_kind, field_ch.field_value, field_ch.source_offset,
              field_ch.final_of_run};
      if (expected_fields.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected field transfer: %p", got);
      end else begin
        want = expected_fields.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("field mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (field_ch.valid && field_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == 5000) begin
        timed_out <= 1'b1;
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

### packet_header_field_extractor_core.f
+incdir+hdl
hdl/pfx_pkg.sv
hdl/pfx_ifs.sv
hdl/pfx_parse.sv
hdl/pfx_runq.sv
hdl/packet_header_field_extractor_core.sv
sim/tb_top.sv
